/* rtl/core/histogram_contrast_stretch_assert.svh */
// ----------------------------------------------------------------------------
// Histogram contrast stretch assertion macros
// Shared concurrent property forms for the contrast stretch block.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_CONTRAST_STRETCH_ASSERT_SVH
`define HISTOGRAM_CONTRAST_STRETCH_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HCS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hcs: same-cycle property failed");

// antecedent implies consequent in the next cycle
`define HCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hcs: next-cycle property failed");

`endif

/* rtl/core/hcs_pkg.sv */
// ----------------------------------------------------------------------------
// hcs_pkg
// Types and constants shared by the contrast stretch lanes and merge stage.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int NUM_LANES = 3;
    localparam logic [7:0] LEVEL_MAX = 8'hFF;
    localparam logic [7:0] LEVEL_MIN = 8'h00;

    typedef logic [1:0] req_t;
    localparam req_t REQ_START   = 2'd0;
    localparam req_t REQ_COLLECT = 2'd1;
    localparam req_t REQ_MAP     = 2'd2;

    typedef enum logic [1:0] {
        L_IDLE,
        L_DIV,
        L_DONE
    } lane_state_t;

    typedef struct packed {
        logic clear;
        logic collect;
        logic map;
        logic active;
        logic any_seen;
    } lane_cmd_t;

    typedef struct packed {
        logic       done;
        logic [7:0] level;
    } lane_stat_t;

endpackage

/* rtl/core/hcs_lane.sv */
// ----------------------------------------------------------------------------
// hcs_lane
// One color channel: keeps its low/high limits and stretches a level with a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hcs_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hcs_pkg::lane_cmd_t    cmd,
    input  logic [7:0]            pix,
    input  logic                  take,
    output hcs_pkg::lane_stat_t   stat
);

    hcs_pkg::lane_state_t state_reg, state_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  quo_reg, quo_next;
    logic [7:0]  div_reg, div_next;
    logic [2:0]  cnt_reg, cnt_next;

    logic [7:0]  span;
    logic [7:0]  diff;
    logic [15:0] num;
    logic [8:0]  trial;
    logic [8:0]  trial_sub;
    logic        trial_ge;

    assign span      = high_reg - low_reg;
    assign diff      = pix - low_reg;
    // 255 * diff
    assign num       = {diff, 8'h00} - {8'h00, diff};
    assign trial     = {rem_reg, quo_reg[7]};
    assign trial_ge  = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    always_comb begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            hcs_pkg::L_IDLE: begin
                if (cmd.clear) begin
                    low_next  = hcs_pkg::LEVEL_MAX;
                    high_next = hcs_pkg::LEVEL_MIN;
                end else if (cmd.collect && cmd.active) begin
                    if (pix < low_reg) begin
                        low_next = pix;
                    end
                    if (pix > high_reg) begin
                        high_next = pix;
                    end
                end else if (cmd.map) begin
                    state_next = hcs_pkg::L_DONE;
                    if (!cmd.active) begin
                        quo_next = hcs_pkg::LEVEL_MIN;
                    end else if (!cmd.any_seen || high_reg <= low_reg) begin
                        quo_next = pix;
                    end else if (pix <= low_reg) begin
                        quo_next = hcs_pkg::LEVEL_MIN;
                    end else if (pix >= high_reg) begin
                        quo_next = hcs_pkg::LEVEL_MAX;
                    end else begin
                        rem_next   = num[15:8];
                        quo_next   = num[7:0];
                        div_next   = span;
                        cnt_next   = 3'd7;
                        state_next = hcs_pkg::L_DIV;
                    end
                end
            end
            hcs_pkg::L_DIV: begin
                rem_next = trial_ge ? trial_sub[7:0] : trial[7:0];
                quo_next = {quo_reg[6:0], trial_ge};
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0) begin
                    state_next = hcs_pkg::L_DONE;
                end
            end
            hcs_pkg::L_DONE: begin
                if (take) begin
                    state_next = hcs_pkg::L_IDLE;
                end
            end
            default: begin
                state_next = hcs_pkg::L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hcs_pkg::L_IDLE;
            low_reg   <= hcs_pkg::LEVEL_MAX;
            high_reg  <= hcs_pkg::LEVEL_MIN;
        end else begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

    assign stat.done  = (state_reg == hcs_pkg::L_DONE);
    assign stat.level = quo_reg;

endmodule

/* rtl/core/hcs_merge.sv */
// ----------------------------------------------------------------------------
// hcs_merge
// Waits for all lanes, packs their levels into the output word register.
// ----------------------------------------------------------------------------
module hcs_merge (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hcs_pkg::lane_stat_t   stat [hcs_pkg::NUM_LANES],
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [23:0]           m_tdata,
    output logic                  take
);

    logic        valid_reg, valid_next;
    logic [23:0] data_reg, data_next;
    logic        all_done;

    assign all_done = stat[0].done && stat[1].done && stat[2].done;
    assign take     = all_done && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (take) begin
            valid_next = 1'b1;
            data_next  = {stat[2].level, stat[1].level, stat[0].level};
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

/* rtl/core/histogram_contrast_stretch.sv */
// ----------------------------------------------------------------------------
// histogram_contrast_stretch
// Start and collect words: one per cycle unless a map is pending; no
// output. Map word: a level saturates, passes through or runs the per-lane
// divider; the next word is taken once the result is merged.
// aresetn clears limits to 255/0, gray_mode, and all handshake state.
// ----------------------------------------------------------------------------
`include "histogram_contrast_stretch_assert.svh"

module histogram_contrast_stretch (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // gray_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // red_or_gray, green_in, blue_in
    input  logic [1:0]  s_tuser,       // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // red_or_gray_out, green_out, blue_out
);

    logic gray_reg, gray_next;
    logic any_seen_reg, any_seen_next;
    logic busy_reg, busy_next;
    logic accept;
    logic take;

    hcs_pkg::lane_cmd_t  cmd  [hcs_pkg::NUM_LANES];
    hcs_pkg::lane_stat_t stat [hcs_pkg::NUM_LANES];

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        gray_next     = gray_reg;
        any_seen_next = any_seen_reg;
        busy_next     = busy_reg;
        if (cfg_valid && cfg_ready) begin
            gray_next = cfg_data;
        end
        if (take) begin
            busy_next = 1'b0;
        end
        if (accept) begin
            unique case (s_tuser)
                hcs_pkg::REQ_START:   any_seen_next = 1'b0;
                hcs_pkg::REQ_COLLECT: any_seen_next = 1'b1;
                hcs_pkg::REQ_MAP:     busy_next     = 1'b1;
                default:              any_seen_next = any_seen_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_reg     <= 1'b0;
            any_seen_reg <= 1'b0;
            busy_reg     <= 1'b0;
        end else begin
            gray_reg     <= gray_next;
            any_seen_reg <= any_seen_next;
            busy_reg     <= busy_next;
        end
    end

    for (genvar i = 0; i < hcs_pkg::NUM_LANES; i++) begin : g_lane
        assign cmd[i].clear    = accept && (s_tuser == hcs_pkg::REQ_START);
        assign cmd[i].collect  = accept && (s_tuser == hcs_pkg::REQ_COLLECT);
        assign cmd[i].map      = accept && (s_tuser == hcs_pkg::REQ_MAP);
        assign cmd[i].active   = (i == 0) || !gray_reg;
        assign cmd[i].any_seen = any_seen_reg;

        hcs_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd[i]),
            .pix     (s_tdata[8*i +: 8]),
            .take    (take),
            .stat    (stat[i])
        );
    end

    hcs_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .take     (take)
    );

    `HCS_ASSERT_NEXT(a_map_blocks_input, aclk, aresetn,
        accept && (s_tuser == hcs_pkg::REQ_MAP), !s_tready)
    `HCS_ASSERT_NEXT(a_collect_sets_seen, aclk, aresetn,
        accept && (s_tuser == hcs_pkg::REQ_COLLECT), any_seen_reg)
    `HCS_ASSERT_SAME(a_take_only_when_busy, aclk, aresetn,
        take, busy_reg && stat[0].done && stat[1].done && stat[2].done)

endmodule

/* tb/histogram_contrast_stretch_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_contrast_stretch testbench
// Runs start, collect and map words through the stream ports and checks each
// stretched pixel against a local min/max tracker. A directed set covers the
// limit corner cases, then random frames run in color and gray mode under
// changing stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module histogram_contrast_stretch_tb;

    localparam hcs_pkg::req_t REQ_UNUSED = 2'd3;
    localparam logic GRAY_OFF       = 1'b0;
    localparam logic GRAY_ON        = 1'b1;
    localparam int   SEGMENT_WORDS  = 280;
    localparam int   SETTLE_CYCLES  = 20;
    localparam int   HOLD_CYCLES    = 300;
    localparam int   CYCLE_LIMIT    = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;         // red_or_gray, green_in, blue_in
    logic [1:0]  s_tuser = '0;         // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;              // red_or_gray_out, green_out, blue_out

    typedef struct packed {
        hcs_pkg::req_t req;
        logic [7:0]    blue;
        logic [7:0]    green;
        logic [7:0]    red;
    } stretch_word_t;

    stretch_word_t pend_words[$];
    logic [23:0]   expected_pixels[$];
    logic [23:0]   want_pixel;

    logic       gray_pred = GRAY_OFF;
    logic [7:0] lim_low[3] = '{8'hFF, 8'hFF, 8'hFF};
    logic [7:0] lim_high[3] = '{8'h00, 8'h00, 8'h00};
    logic       limits_seen = 1'b0;

    int send_idle = 0;
    int recv_idle = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int err_count = 0;
    int cycle_count = 0;
    int words_added = 0;

    histogram_contrast_stretch dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] stretch_level(input logic [7:0] lo, input logic [7:0] hi,
                                                 input logic [7:0] v, input logic seen);
        int unsigned num;
        int unsigned den;
        if (!seen || hi <= lo) return v;
        if (v <= lo) return hcs_pkg::LEVEL_MIN;
        if (v >= hi) return hcs_pkg::LEVEL_MAX;
        num = int'(hcs_pkg::LEVEL_MAX) * (v - lo);
        den = hi - lo;
        return 8'(num / den);
    endfunction

    task automatic track_word(input hcs_pkg::req_t req, input logic [23:0] data);
        logic [7:0]  px[3];
        logic [23:0] pix_out;
        int active;
        for (int c = 0; c < 3; c++) px[c] = data[8*c +: 8];
        active = gray_pred ? 1 : hcs_pkg::NUM_LANES;
        unique case (req)
            hcs_pkg::REQ_START: begin
                for (int c = 0; c < 3; c++) begin
                    lim_low[c] = hcs_pkg::LEVEL_MAX;
                    lim_high[c] = hcs_pkg::LEVEL_MIN;
                end
                limits_seen = 1'b0;
            end
            hcs_pkg::REQ_COLLECT: begin
                for (int c = 0; c < active; c++) begin
                    if (px[c] < lim_low[c]) lim_low[c] = px[c];
                    if (px[c] > lim_high[c]) lim_high[c] = px[c];
                end
                limits_seen = 1'b1;
            end
            hcs_pkg::REQ_MAP: begin
                pix_out = '0;
                for (int c = 0; c < active; c++)
                    pix_out[8*c +: 8] = stretch_level(lim_low[c], lim_high[c], px[c],
                                                      limits_seen);
                expected_pixels.push_back(pix_out);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [23:0] want,
                                   input logic [23:0] got);
        $display("%0t: %s mismatch: expected %h got %h", $time, what, want, got);
        err_count++;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) track_word(hcs_pkg::req_t'(s_tuser), s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pend_words.size() != 0 && $urandom_range(99) >= send_idle) begin
                    stretch_word_t w;
                    w = pend_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= w.req;
                    s_tdata <= {w.blue, w.green, w.red};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected word", '0, m_tdata);
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (want_pixel[7:0] !== m_tdata[7:0])
                    report_mismatch("red_or_gray_out", want_pixel[7:0], m_tdata[7:0]);
                if (want_pixel[15:8] !== m_tdata[15:8])
                    report_mismatch("green_out", want_pixel[15:8], m_tdata[15:8]);
                if (want_pixel[23:16] !== m_tdata[23:16])
                    report_mismatch("blue_out", want_pixel[23:16], m_tdata[23:16]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("histogram_contrast_stretch regression: fail");
            $finish;
        end
    end

    task automatic push_word(input hcs_pkg::req_t req, input int red, input int green,
                             input int blue);
        stretch_word_t w;
        w.req = req;
        w.red = 8'(red);
        w.green = 8'(green);
        w.blue = 8'(blue);
        pend_words.push_back(w);
        if (req != REQ_UNUSED) words_added++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pend_words.size() != 0 || s_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_gray_mode(input logic mode);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gray_pred = mode;
        @(negedge aclk);
    endtask

    function automatic int pick_level(input int center, input int spread);
        int v;
        v = center - spread + $urandom_range(2 * spread);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v;
    endfunction

    task automatic add_frame();
        int roll;
        int n;
        int center[3];
        int spread[3];
        roll = $urandom_range(99);
        if (roll < 80) begin
            push_word(hcs_pkg::REQ_START, $urandom_range(255), $urandom_range(255),
                      $urandom_range(255));
            for (int c = 0; c < 3; c++) begin
                center[c] = $urandom_range(255);
                spread[c] = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 80);
            end
            n = $urandom_range(1, 6);
            repeat (n)
                push_word(hcs_pkg::REQ_COLLECT, pick_level(center[0], spread[0]),
                          pick_level(center[1], spread[1]), pick_level(center[2], spread[2]));
            n = $urandom_range(1, 12);
            repeat (n) begin
                if ($urandom_range(1))
                    push_word(hcs_pkg::REQ_MAP, pick_level(center[0], spread[0] + 20),
                              pick_level(center[1], spread[1] + 20),
                              pick_level(center[2], spread[2] + 20));
                else
                    push_word(hcs_pkg::REQ_MAP, $urandom_range(255), $urandom_range(255),
                              $urandom_range(255));
            end
        end else if (roll < 90) begin
            n = $urandom_range(1, 6);
            repeat (n)
                push_word($urandom_range(1) ? hcs_pkg::REQ_COLLECT : hcs_pkg::REQ_MAP,
                          $urandom_range(255), $urandom_range(255), $urandom_range(255));
        end else begin
            n = $urandom_range(1, 4);
            repeat (n)
                push_word(hcs_pkg::req_t'($urandom_range(3)), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255));
        end
    endtask

    initial begin
        send_idle = 24;
        recv_idle = 77;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // color mode from reset: untouched limits, then limits set per channel
        push_word(hcs_pkg::REQ_MAP, 0, 128, 255);
        push_word(hcs_pkg::REQ_START, 255, 255, 255);
        push_word(hcs_pkg::REQ_MAP, 7, 8, 9);
        push_word(hcs_pkg::REQ_COLLECT, 10, 20, 0);
        push_word(hcs_pkg::REQ_COLLECT, 200, 20, 255);
        push_word(hcs_pkg::REQ_MAP, 10, 20, 0);
        push_word(hcs_pkg::REQ_MAP, 200, 19, 255);
        push_word(hcs_pkg::REQ_MAP, 5, 255, 128);
        push_word(hcs_pkg::REQ_MAP, 255, 0, 127);
        push_word(hcs_pkg::REQ_MAP, 105, 21, 1);
        push_word(REQ_UNUSED, 0, 0, 0);
        push_word(hcs_pkg::REQ_MAP, 106, 20, 254);
        wait_drained();

        write_gray_mode(GRAY_ON);
        push_word(hcs_pkg::REQ_START, 0, 0, 0);
        push_word(hcs_pkg::REQ_MAP, 99, 200, 33);
        push_word(hcs_pkg::REQ_COLLECT, 50, 255, 0);
        push_word(hcs_pkg::REQ_COLLECT, 150, 0, 255);
        push_word(hcs_pkg::REQ_MAP, 100, 255, 255);
        push_word(hcs_pkg::REQ_MAP, 0, 1, 2);
        push_word(hcs_pkg::REQ_MAP, 255, 3, 4);
        push_word(hcs_pkg::REQ_MAP, 50, 5, 6);
        push_word(hcs_pkg::REQ_MAP, 149, 7, 8);
        wait_drained();

        // green and blue were never collected in gray mode
        write_gray_mode(GRAY_OFF);
        push_word(hcs_pkg::REQ_MAP, 100, 77, 200);
        push_word(hcs_pkg::REQ_MAP, 150, 0, 255);
        wait_drained();

        for (int seg = 0; seg < 6; seg++) begin
            write_gray_mode((seg % 2) ? GRAY_ON : GRAY_OFF);
            unique case (seg / 2)
                0: begin
                    send_idle <= 24;
                    recv_idle <= 77;
                end
                1: begin
                    send_idle <= 77;
                    recv_idle <= 24;
                end
                default: begin
                    send_idle <= 0;
                    recv_idle <= 0;
                end
            endcase
            @(negedge aclk);
            words_added = 0;
            while (words_added < SEGMENT_WORDS) add_frame();
            if (seg == 4) hold_req <= 1'b1;
            wait_drained();
        end

        if (err_count == 0) begin
            $display("histogram_contrast_stretch regression: pass");
        end else begin
            $display("histogram_contrast_stretch regression: fail");
        end
        $finish;
    end

endmodule

/* histogram_contrast_stretch.f */
+incdir+rtl/core
rtl/core/hcs_pkg.sv
rtl/core/hcs_lane.sv
rtl/core/hcs_merge.sv
rtl/core/histogram_contrast_stretch.sv
tb/histogram_contrast_stretch_tb.sv
